// ----- hdl/bnc_pkg.sv -----
// Package with shared types, constants and decode functions for the bracket nesting checker.
`timescale 1ns / 1ps

package bnc_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int CHAR_W              = 8;
   localparam int KIND_W              = 2;
   localparam int DEPTH_OUT_W         = 7;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [CHAR_W-1:0] CHAR_OPEN_CURLY   = 8'h7B;
   localparam logic [CHAR_W-1:0] CHAR_OPEN_SQUARE  = 8'h5B;
   localparam logic [CHAR_W-1:0] CHAR_OPEN_ROUND   = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE_CURLY  = 8'h7D;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE_SQUARE = 8'h5D;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE_ROUND  = 8'h29;

   typedef enum logic [KIND_W-1:0] {
      KIND_CURLY  = 2'd0,
      KIND_SQUARE = 2'd1,
      KIND_ROUND  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_OK          = 2'd0,
      ERR_MISMATCH    = 2'd1,
      ERR_NOT_STARTED = 2'd2,
      ERR_OVERFLOW    = 2'd3
   } err_type;

   // Decoded character as it travels from the front to the back.
   typedef struct packed {
      logic     is_open;
      logic     is_close;
      kind_type kind;
   } class_type;

   typedef struct packed {
      logic                   block_done;
      err_type                error_code;
      logic [CHAR_W-1:0]      expected_close;
      logic [DEPTH_OUT_W-1:0] nest_depth;
   } rsp_type;

   function automatic class_type classify(input logic [CHAR_W-1:0] c);
      class_type r;
      r.is_open  = 1'b0;
      r.is_close = 1'b0;
      r.kind     = KIND_NONE;
      case (c)
         CHAR_OPEN_CURLY: begin
            r.is_open = 1'b1;
            r.kind    = KIND_CURLY;
         end
         CHAR_OPEN_SQUARE: begin
            r.is_open = 1'b1;
            r.kind    = KIND_SQUARE;
         end
         CHAR_OPEN_ROUND: begin
            r.is_open = 1'b1;
            r.kind    = KIND_ROUND;
         end
         CHAR_CLOSE_CURLY: begin
            r.is_close = 1'b1;
            r.kind     = KIND_CURLY;
         end
         CHAR_CLOSE_SQUARE: begin
            r.is_close = 1'b1;
            r.kind     = KIND_SQUARE;
         end
         CHAR_CLOSE_ROUND: begin
            r.is_close = 1'b1;
            r.kind     = KIND_ROUND;
         end
         default: begin
            r.kind = KIND_NONE;
         end
      endcase
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] close_char(input kind_type k);
      logic [CHAR_W-1:0] r;
      case (k)
         KIND_SQUARE: r = CHAR_CLOSE_SQUARE;
         KIND_ROUND:  r = CHAR_CLOSE_ROUND;
         default:     r = CHAR_CLOSE_CURLY;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/bnc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bnc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/bnc_front.sv -----
// Front end: accepts characters, decodes bracket kind and buffers them in a short queue.
`timescale 1ns / 1ps

module bnc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [bnc_pkg::CHAR_W-1:0] req_char_in,
   output logic                      q_valid,
   input  logic                      q_ready,
   output bnc_pkg::class_type        q_data
);
   import bnc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   class_type         queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              push;
   logic              pop;

   always_comb begin
      req_ready = (fill_ff != CNT_W'(QUEUE_DEPTH));
      q_valid   = (fill_ff != '0);
      q_data    = queue_ff[rd_ptr_ff];
      push      = req_valid && req_ready;
      pop       = q_valid && q_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end

      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classify(req_char_in);
      end
   end

endmodule

// ----- hdl/bnc_back.sv -----
// Back end: kind stack with cached top entry, checking logic and result register.
`timescale 1ns / 1ps

module bnc_back #(
   parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  bnc_pkg::class_type q_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bnc_pkg::rsp_type   rsp_data
);
   import bnc_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   logic [CNT_W-1:0]             count_ff, count_in;
   kind_type                     top_ff, top_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;
   logic                         fire;
   logic                         wr_en;
   logic [ADDR_W-1:0]            wr_addr;
   logic [ADDR_W-1:0]            rd_addr;
   logic [KIND_W-1:0]            rd_data;
   logic [CNT_W-1:0]             below_top;
   logic [CNT_W+DEPTH_OUT_W-1:0] depth_wide;

   // The RAM always holds the entry just below the top of the stack on its
   // read port, so a pop can refill the cached top in the same cycle.
   bnc_ram #(
      .WIDTH(KIND_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(q_data.kind),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      q_ready  = !rsp_valid_ff || rsp_ready;
      fire     = q_valid && q_ready;
      count_in = count_ff;
      top_in   = top_ff;
      wr_en    = 1'b0;
      wr_addr  = count_ff[ADDR_W-1:0];

      rsp_in.block_done     = 1'b0;
      rsp_in.error_code     = ERR_OK;
      rsp_in.expected_close = '0;

      if (fire) begin
         if (count_ff == '0) begin
            if (q_data.is_open) begin
               wr_en    = 1'b1;
               top_in   = q_data.kind;
               count_in = CNT_W'(1);
            end else begin
               rsp_in.error_code     = ERR_NOT_STARTED;
               rsp_in.expected_close = CHAR_CLOSE_CURLY;
            end
         end else if (q_data.is_open) begin
            if (count_ff == CNT_W'(STACK_DEPTH)) begin
               rsp_in.error_code = ERR_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               top_in   = q_data.kind;
               count_in = count_ff + 1'b1;
            end
         end else if (q_data.is_close) begin
            if (top_ff != q_data.kind) begin
               rsp_in.error_code     = ERR_MISMATCH;
               rsp_in.expected_close = close_char(top_ff);
            end else begin
               count_in          = count_ff - 1'b1;
               top_in            = kind_type'(rd_data);
               rsp_in.block_done = (count_ff == CNT_W'(1));
            end
         end
      end

      below_top         = count_in - CNT_W'(2);
      rd_addr           = below_top[ADDR_W-1:0];
      depth_wide        = {DEPTH_OUT_W'(0), count_in};
      rsp_in.nest_depth = depth_wide[DEPTH_OUT_W-1:0];

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/bracket_nesting_checker_unit.sv -----
// An accepted character is decoded into the queue, and its result is then checked into the result
// register, from which the result beat is offered to the receiver.
// Throughput: one character per cycle, sustained while the receiver takes every result; the
// queue and the result register absorb a stall on the result side until the queue fills.
// The stack top is cached in a register and the RAM read port tracks the entry below it.
// Reset (synchronous, active high) empties the stack, the queue and the result register;
// the stack RAM is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module bracket_nesting_checker_unit #(
   parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bnc_pkg::CHAR_W-1:0]      req_char_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_block_done,
   output logic [1:0]                     rsp_error_code,
   output logic [bnc_pkg::CHAR_W-1:0]      rsp_expected_close,
   output logic [bnc_pkg::DEPTH_OUT_W-1:0] rsp_nest_depth
);
   import bnc_pkg::*;

   logic      q_valid;
   logic      q_ready;
   class_type q_data;
   rsp_type   rsp_data;

   bnc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_char_in(req_char_in),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_data     (q_data)
   );

   bnc_back #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_data   (q_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   assign rsp_block_done     = rsp_data.block_done;
   assign rsp_error_code     = rsp_data.error_code;
   assign rsp_expected_close = rsp_data.expected_close;
   assign rsp_nest_depth     = rsp_data.nest_depth;

endmodule

// ----- hdl/bnc_checker.sv -----
// Port-level assertions for the bracket nesting checker, bound to the top level.
`timescale 1ns / 1ps

module bnc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_block_done,
   input logic [1:0]                     rsp_error_code,
   input logic [bnc_pkg::CHAR_W-1:0]      rsp_expected_close,
   input logic [bnc_pkg::DEPTH_OUT_W-1:0] rsp_nest_depth
);
   import bnc_pkg::*;

   // A stalled result beat must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_error_code)
         && $stable(rsp_nest_depth) && $stable(rsp_expected_close))
      else $error("result beat changed while stalled");

   // Closing the outermost bracket leaves an empty stack and no error.
   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_done |-> rsp_nest_depth == '0 && rsp_error_code == ERR_OK)
      else $error("block end with open brackets or an error");

   // Outside a block only an opener is legal, and the stack stays empty.
   a_not_started: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_NOT_STARTED
         |-> rsp_nest_depth == '0 && rsp_expected_close == CHAR_CLOSE_CURLY)
      else $error("not-started error with nonempty stack or wrong closer");

   // A mismatch names a real closer and can only happen inside a block.
   a_mismatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_MISMATCH
         |-> rsp_nest_depth != '0 && (rsp_expected_close == CHAR_CLOSE_CURLY
            || rsp_expected_close == CHAR_CLOSE_SQUARE
            || rsp_expected_close == CHAR_CLOSE_ROUND))
      else $error("mismatch error with bad expected closer");

endmodule

bind bracket_nesting_checker_unit bnc_checker u_bnc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_block_done    (rsp_block_done),
   .rsp_error_code    (rsp_error_code),
   .rsp_expected_close(rsp_expected_close),
   .rsp_nest_depth    (rsp_nest_depth)
);

// ----- tb/sv/bracket_nesting_checker_unit_tb.sv -----
// Self-checking testbench for the bracket nesting checker unit.
`timescale 1ns / 1ps

module bracket_nesting_checker_unit_tb;
   import bnc_pkg::*;

   localparam int STACK_DEPTH = STACK_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 10;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [CHAR_W-1:0]      req_char_in;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_block_done;
   logic [1:0]             rsp_error_code;
   logic [CHAR_W-1:0]      rsp_expected_close;
   logic [DEPTH_OUT_W-1:0] rsp_nest_depth;

   // Shadow of the bracket stack, updated as each character is accepted.
   kind_type    open_kinds [STACK_DEPTH];
   int unsigned open_count;
   rsp_type     pending_rsp_q [$];
   rsp_type     oldest_rsp;

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned hold_cycles;
   int unsigned fail_count;
   int unsigned cycle_count;

   bracket_nesting_checker_unit #(
      .STACK_DEPTH(STACK_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_char_in(req_char_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_block_done(rsp_block_done),
      .rsp_error_code(rsp_error_code),
      .rsp_expected_close(rsp_expected_close),
      .rsp_nest_depth(rsp_nest_depth)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic kind_type opener_kind(input logic [CHAR_W-1:0] c);
      if (c == CHAR_OPEN_CURLY) return KIND_CURLY;
      if (c == CHAR_OPEN_SQUARE) return KIND_SQUARE;
      if (c == CHAR_OPEN_ROUND) return KIND_ROUND;
      return KIND_NONE;
   endfunction

   function automatic kind_type closer_kind(input logic [CHAR_W-1:0] c);
      if (c == CHAR_CLOSE_CURLY) return KIND_CURLY;
      if (c == CHAR_CLOSE_SQUARE) return KIND_SQUARE;
      if (c == CHAR_CLOSE_ROUND) return KIND_ROUND;
      return KIND_NONE;
   endfunction

   function automatic logic [CHAR_W-1:0] open_char_of(input kind_type k);
      case (k)
         KIND_SQUARE: return CHAR_OPEN_SQUARE;
         KIND_ROUND:  return CHAR_OPEN_ROUND;
         default:     return CHAR_OPEN_CURLY;
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] close_char_of(input kind_type k);
      case (k)
         KIND_SQUARE: return CHAR_CLOSE_SQUARE;
         KIND_ROUND:  return CHAR_CLOSE_ROUND;
         default:     return CHAR_CLOSE_CURLY;
      endcase
   endfunction

   function automatic kind_type any_kind();
      return kind_type'($urandom_range(0, 2));
   endfunction

   // Applies one character to the shadow stack and returns the result it must produce.
   function automatic rsp_type track_nesting(input logic [CHAR_W-1:0] c);
      rsp_type  r;
      kind_type ok;
      kind_type ck;
      ok = opener_kind(c);
      ck = closer_kind(c);
      r.block_done     = 1'b0;
      r.error_code     = ERR_OK;
      r.expected_close = '0;
      if (open_count == 0) begin
         if (ok != KIND_NONE) begin
            open_kinds[0] = ok;
            open_count    = 1;
         end else begin
            r.error_code     = ERR_NOT_STARTED;
            r.expected_close = CHAR_CLOSE_CURLY;
         end
      end else if (ok != KIND_NONE) begin
         if (open_count >= STACK_DEPTH) begin
            r.error_code = ERR_OVERFLOW;
         end else begin
            open_kinds[open_count] = ok;
            open_count++;
         end
      end else if (ck != KIND_NONE) begin
         if (open_kinds[open_count-1] != ck) begin
            r.error_code     = ERR_MISMATCH;
            r.expected_close = close_char_of(open_kinds[open_count-1]);
         end else begin
            open_count--;
            if (open_count == 0) r.block_done = 1'b1;
         end
      end
      r.nest_depth = DEPTH_OUT_W'(open_count);
      return r;
   endfunction

   function automatic kind_type top_kind();
      return open_kinds[open_count-1];
   endfunction

   // Offers one character, idling first at random, and records its expected result
   // at the edge where the beat is taken.
   task automatic send_char(input logic [CHAR_W-1:0] c);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid   = 1'b0;
         req_char_in = CHAR_W'($urandom);
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_char_in = c;
      do @(posedge clock); while (!req_ready);
      pending_rsp_q.push_back(track_nesting(c));
   endtask

   task automatic release_valid();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      release_valid();
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Edge values of the byte, every bracket, both mismatch directions and
   // outermost closes, plus closers and plain bytes on an empty stack.
   task automatic test_directed();
      logic [CHAR_W-1:0] seq [$];
      seq = '{"a", CHAR_CLOSE_ROUND, 8'h00, 8'hFF,
              CHAR_OPEN_CURLY, CHAR_OPEN_SQUARE, CHAR_OPEN_ROUND, "x",
              CHAR_CLOSE_SQUARE, CHAR_CLOSE_ROUND, CHAR_CLOSE_CURLY, 8'hFF,
              CHAR_CLOSE_SQUARE, 8'h00, CHAR_CLOSE_CURLY, CHAR_CLOSE_CURLY,
              CHAR_OPEN_ROUND, CHAR_CLOSE_CURLY, CHAR_CLOSE_ROUND,
              CHAR_OPEN_SQUARE, CHAR_CLOSE_SQUARE};
      foreach (seq[i]) send_char(seq[i]);
   endtask

   // Fills the stack, pushes past the top, sends a wrong closer, then unwinds it with filler in between.
   task automatic test_deep_nesting();
      while (open_count < STACK_DEPTH) send_char(open_char_of(any_kind()));
      repeat (3) send_char(open_char_of(any_kind()));
      send_char(close_char_of(kind_type'((top_kind() + 1 + $urandom_range(0, 1)) % 3)));
      while (open_count > 0) begin
         if ($urandom_range(0, 3) == 0) begin
            send_char(CHAR_W'($urandom));
         end else begin
            send_char(close_char_of(top_kind()));
         end
      end
   endtask

   // Mostly well-formed blocks with random content; the rest is noise,
   // wrong closers and stray openers.
   task automatic test_random_stream(input int unsigned n, input int unsigned max_nest);
      int unsigned pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (open_count == 0) begin
            if (pick < 80) send_char(open_char_of(any_kind()));
            else send_char(CHAR_W'($urandom));
         end else if (pick < 40 && open_count < max_nest) begin
            send_char(open_char_of(any_kind()));
         end else if (pick < 75) begin
            send_char(close_char_of(top_kind()));
         end else if (pick < 88) begin
            send_char(CHAR_W'($urandom));
         end else if (pick < 95) begin
            send_char(close_char_of(kind_type'((top_kind() + 1 + $urandom_range(0, 1)) % 3)));
         end else begin
            send_char(open_char_of(any_kind()));
         end
      end
   endtask

   // The receiver holds off long enough for the unit to fill and stall its input.
   task automatic test_backpressure();
      set_idling(0, 0);
      hold_cycles = 200;
      test_random_stream(40, 6);
      wait_drained();
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_char_in = '0;
      open_count  = 0;
      fail_count  = 0;
      hold_cycles = 0;
      set_idling(0, 0);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_deep_nesting();
      set_idling(86, 0);
      test_random_stream(60, 6);
      set_idling(0, 86);
      test_random_stream(60, 6);
      test_deep_nesting();
      set_idling(16, 16);
      test_random_stream(70, 12);
      test_backpressure();
      set_idling(0, 0);
      test_random_stream(70, 4);
      set_idling(16, 16);
      test_random_stream(30, 3);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Result side: ready toggles at random, or stays low while a hold-off runs.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready   = 1'b0;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            $error("result beat with nothing expected: depth %0d, error %0d",
                   rsp_nest_depth, rsp_error_code);
            fail_count++;
         end else begin
            oldest_rsp = pending_rsp_q.pop_front();
            check_field("block_done", oldest_rsp.block_done, rsp_block_done);
            check_field("error_code", oldest_rsp.error_code, rsp_error_code);
            check_field("expected_close", oldest_rsp.expected_close, rsp_expected_close);
            check_field("nest_depth", oldest_rsp.nest_depth, rsp_nest_depth);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- bracket_nesting_checker_unit.f -----
hdl/bnc_pkg.sv
hdl/bnc_ram.sv
hdl/bnc_front.sv
hdl/bnc_back.sv
hdl/bracket_nesting_checker_unit.sv
hdl/bnc_checker.sv
tb/sv/bracket_nesting_checker_unit_tb.sv
